// File: hdl/wrh_pkg.sv
// Package with shared types and constants of the water ripple height field.
package wrh_pkg;

  localparam int unsigned GridWidth  = 256;
  localparam int unsigned GridHeight = 256;
  localparam int unsigned XW         = $clog2(GridWidth);
  localparam int unsigned YW         = $clog2(GridHeight);
  localparam int unsigned AW         = XW + YW;
  localparam int unsigned Cells      = GridWidth * GridHeight;
  localparam logic [4:0]  DampReset  = 5'd5;

  typedef enum logic [2:0] {
    ActStep    = 3'd0,
    ActBlob    = 3'd1,
    ActBox     = 3'd2,
    ActFlatten = 3'd3,
    ActRead    = 3'd4
  } action_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  x_pos;
    logic [7:0]  y_pos;
    logic [6:0]  radius;
    logic [31:0] amount;
  } req_t;

  typedef struct packed {
    logic [31:0] height_value;
    logic [2:0]  done_action;
  } rsp_t;

endpackage

// File: hdl/wrh_req_if.sv
// Valid/ready channel interface for request items.
interface wrh_req_if;
  logic          valid;
  logic          ready;
  wrh_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/wrh_rsp_if.sv
// Valid/ready channel interface for result items.
interface wrh_rsp_if;
  logic          valid;
  logic          ready;
  wrh_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/wrh_cfg_if.sv
// Valid/ready write channel for the damping shift register.
interface wrh_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/wrh_field_ram.sv
// Single-port-write, single-port-read height field memory with registered read.
module wrh_field_ram (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [wrh_pkg::AW-1:0] waddr_i,
  input  logic [31:0]            wdata_i,
  input  logic [wrh_pkg::AW-1:0] raddr_i,
  output logic [31:0]            rdata_o
);
  logic [31:0] mem [wrh_pkg::Cells];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

// File: hdl/water_ripple_height_field.sv
// Top level of the water ripple height field engine.
// Requests arrive on req (action, x_pos, y_pos, radius, amount); each gives
// exactly one result on rsp (height_value, done_action). Configuration writes
// on cfg set the damping shift; they are taken only while the block is idle,
// and reset gives 5.
// Both fields live in one memory each with one write and one registered read
// port, and a single sequencer steps through cells with one adder path.
// After reset a clearing pass writes zero to every cell of both fields,
// during which no request is taken. Flatten runs the same pass. A step
// reads the nine cells of a 3x3 window and then writes the new cell, for
// every interior cell. A blob or box visits its window for up to (2r)^2
// cells; a read passes SReadRd, SReadWait and SDone before its result,
// and undefined action codes go straight to SDone.
// The result is held in an output register until taken; while the receiver
// stalls the block keeps the result and takes no new request.
module water_ripple_height_field (
  input logic        clk_i,
  input logic        rst_ni,
  wrh_req_if.sink    req,
  wrh_rsp_if.source  rsp,
  wrh_cfg_if.sink    cfg
);
  localparam int unsigned AW = wrh_pkg::AW;
  localparam int unsigned XW = wrh_pkg::XW;
  localparam int unsigned YW = wrh_pkg::YW;

  typedef enum logic [3:0] {
    SClear, SIdle, SStepRd, SStepWait, SStepWr, SPaintRd, SPaintWait,
    SPaintWr, SReadRd, SReadWait, SDone
  } state_e;

  state_e      state_q;
  logic [4:0]  damp_q;
  logic        page_q;
  wrh_pkg::req_t r_q;
  logic [AW-1:0] cnt_q;
  logic [YW:0]   row_q;
  logic [XW:0]   col_q;
  logic [3:0]    tap_q;
  logic [31:0]   acc_q;
  logic [31:0]   rsp_val_q;
  logic          rsp_valid_q;
  // Paint window, signed offsets relative to the centre.
  logic signed [9:0] left_q, right_q, bot_q, dx_q, dy_q;

  logic          we_a, we_b;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rd_a, rd_b;

  wrh_field_ram u_ram_a (.clk_i, .we_i(we_a), .waddr_i(waddr), .wdata_i(wdata),
                         .raddr_i(raddr), .rdata_o(rd_a));
  wrh_field_ram u_ram_b (.clk_i, .we_i(we_b), .waddr_i(waddr), .wdata_i(wdata),
                         .raddr_i(raddr), .rdata_o(rd_b));

  assign cfg.ready  = (state_q == SIdle);
  assign req.ready  = (state_q == SIdle) && !rsp_valid_q;
  assign rsp.valid  = rsp_valid_q;
  assign rsp.data.height_value = rsp_val_q;
  assign rsp.data.done_action  = r_q.action;

  // Step neighbour taps: tap 0..7 the old-field neighbours, tap 8 the cell.
  logic signed [1:0] tdx, tdy;
  always_comb begin
    unique case (tap_q)
      4'd0: begin tdx = -2'sd1; tdy = -2'sd1; end
      4'd1: begin tdx =  2'sd0; tdy = -2'sd1; end
      4'd2: begin tdx =  2'sd1; tdy = -2'sd1; end
      4'd3: begin tdx = -2'sd1; tdy =  2'sd0; end
      4'd4: begin tdx =  2'sd1; tdy =  2'sd0; end
      4'd5: begin tdx = -2'sd1; tdy =  2'sd1; end
      4'd6: begin tdx =  2'sd0; tdy =  2'sd1; end
      4'd7: begin tdx =  2'sd1; tdy =  2'sd1; end
      default: begin tdx = 2'sd0; tdy = 2'sd0; end
    endcase
  end

  logic [XW-1:0] tcol;
  logic [YW-1:0] trow;
  assign tcol = XW'(col_q + {{(XW-1){tdx[1]}}, tdx});
  assign trow = YW'(row_q + {{(YW-1){tdy[1]}}, tdy});

  logic [XW-1:0] pcol;
  logic [YW-1:0] prow;
  assign pcol = XW'($signed({2'b00, r_q.x_pos}) + dx_q);
  assign prow = YW'($signed({2'b00, r_q.y_pos}) + dy_q);

  logic [AW-1:0] cell_addr;
  assign cell_addr = {row_q[YW-1:0], col_q[XW-1:0]};

  // Memory read address per state; the step and paint wait states hold it so that the
  // registered data is still that cell when the write state uses it.
  always_comb begin
    unique case (state_q)
      SStepRd, SStepWait:   raddr = {trow, tcol};
      SPaintRd, SPaintWait: raddr = {prow, pcol};
      SReadRd:  raddr = {r_q.y_pos[YW-1:0], r_q.x_pos[XW-1:0]};
      default:  raddr = '0;
    endcase
  end

  logic [31:0] rd_new, rd_old, v, nv, paint_v;
  assign rd_new = page_q ? rd_b : rd_a;
  assign rd_old = page_q ? rd_a : rd_b;
  assign v  = 32'($signed(acc_q) >>> 2) - rd_new;
  assign nv = v - 32'($signed(v) >>> damp_q);
  assign paint_v = (r_q.action == wrh_pkg::ActBlob) ? rd_new + r_q.amount : r_q.amount;

  logic signed [15:0] d2;
  logic               in_circle;
  assign d2 = dx_q * dx_q + dy_q * dy_q;
  assign in_circle = (r_q.action != wrh_pkg::ActBlob) ||
                     (d2 < $signed({9'd0, r_q.radius}) * $signed({9'd0, r_q.radius}));

  always_comb begin
    we_a = 1'b0; we_b = 1'b0; waddr = cell_addr; wdata = '0;
    unique case (state_q)
      SClear: begin
        we_a = 1'b1; we_b = 1'b1; waddr = cnt_q;
      end
      SStepWr: begin
        we_a = !page_q; we_b = page_q; wdata = nv;
      end
      SPaintWr: begin
        we_a = !page_q && in_circle; we_b = page_q && in_circle;
        waddr = {prow, pcol}; wdata = paint_v;
      end
      default: ;
    endcase
  end

  // Clipped window bounds for a paint request.
  logic signed [9:0] xs, ys, rs, lft, rgt, tp, bt;
  always_comb begin
    xs = $signed({2'b00, req.data.x_pos});
    ys = $signed({2'b00, req.data.y_pos});
    rs = $signed({3'b000, req.data.radius});
    lft = (xs - rs < 10'sd1) ? 10'sd1 - xs : -rs;
    tp  = (ys - rs < 10'sd1) ? 10'sd1 - ys : -rs;
    rgt = (xs + rs > 10'(wrh_pkg::GridWidth - 1)) ? 10'(wrh_pkg::GridWidth - 1) - xs : rs;
    bt  = (ys + rs > 10'(wrh_pkg::GridHeight - 1)) ? 10'(wrh_pkg::GridHeight - 1) - ys : rs;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear;
      damp_q <= wrh_pkg::DampReset;
      page_q <= 1'b0;
      cnt_q <= '0;
      rsp_valid_q <= 1'b0;
      r_q <= '0;
      row_q <= '0; col_q <= '0; tap_q <= '0; acc_q <= '0; rsp_val_q <= '0;
      left_q <= '0; right_q <= '0; bot_q <= '0; dx_q <= '0; dy_q <= '0;
    end else begin
      if (cfg.valid && cfg.ready) damp_q <= cfg.data;
      if (rsp_valid_q && rsp.ready) rsp_valid_q <= 1'b0;
      unique case (state_q)
        SClear: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == AW'(wrh_pkg::Cells - 1)) begin
            state_q <= (r_q.action == wrh_pkg::ActFlatten) ? SDone : SIdle;
          end
        end
        SIdle: begin
          if (req.valid && req.ready) begin
            r_q <= req.data;
            rsp_val_q <= '0;
            left_q <= lft; right_q <= rgt; bot_q <= bt;
            dx_q <= lft; dy_q <= tp;
            row_q <= (YW+1)'(1); col_q <= (XW+1)'(1);
            tap_q <= '0; acc_q <= '0; cnt_q <= '0;
            unique case (req.data.action)
              wrh_pkg::ActStep:    state_q <= SStepRd;
              wrh_pkg::ActBlob, wrh_pkg::ActBox:
                state_q <= (lft < rgt && tp < bt) ? SPaintRd : SDone;
              wrh_pkg::ActFlatten: state_q <= SClear;
              wrh_pkg::ActRead:    state_q <= SReadRd;
              default:             state_q <= SDone;
            endcase
          end
        end
        SStepRd:   state_q <= SStepWait;
        SStepWait: begin
          if (tap_q == 4'd8) begin
            state_q <= SStepWr;
          end else begin
            acc_q <= acc_q + rd_old;
            tap_q <= tap_q + 1'b1;
            state_q <= SStepRd;
          end
        end
        SStepWr: begin
          tap_q <= '0; acc_q <= '0;
          if (col_q == (XW+1)'(wrh_pkg::GridWidth - 2)) begin
            col_q <= (XW+1)'(1);
            if (row_q == (YW+1)'(wrh_pkg::GridHeight - 2)) begin
              page_q <= !page_q;
              state_q <= SDone;
            end else begin
              row_q <= row_q + 1'b1;
              state_q <= SStepRd;
            end
          end else begin
            col_q <= col_q + 1'b1;
            state_q <= SStepRd;
          end
        end
        SPaintRd:   state_q <= SPaintWait;
        SPaintWait: state_q <= SPaintWr;
        SPaintWr: begin
          if (dx_q + 10'sd1 == right_q) begin
            dx_q <= left_q;
            dy_q <= dy_q + 10'sd1;
            state_q <= (dy_q + 10'sd1 == bot_q) ? SDone : SPaintRd;
          end else begin
            dx_q <= dx_q + 10'sd1;
            state_q <= SPaintRd;
          end
        end
        SReadRd:   state_q <= SReadWait;
        SReadWait: begin
          rsp_val_q <= page_q ? rd_a : rd_b;
          state_q <= SDone;
        end
        SDone: begin
          rsp_valid_q <= 1'b1;
          state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end
endmodule
